>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/tlq_pkg.sv
`timescale 1ns / 1ps
package tlq_pkg;
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 4;
    localparam int WID_W      = 12;
    localparam int VERT_W     = 18;
    localparam int COLOR_W    = 32;
    localparam int NUM_W      = COORD_BITS + WID_W;
    localparam int L2_W       = 2 * COORD_BITS + 1;
    localparam int PW         = L2_W + 2 * (WID_W + 1) + 1;
    localparam int GW         = WID_W + L2_W;
    localparam int SQ_STEPS   = WID_W;
    localparam int CFG_IDX_W  = 2;
    localparam int IDX_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 2'd2;

    localparam logic [WID_W-1:0]   RST_LINE_WIDTH = 12'd64;
    localparam logic [COLOR_W-1:0] RST_LINE_COLOR = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] RST_BACK_COLOR = 32'h9999_9980;

    typedef struct packed {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        logic                  neg;
        logic                  degen;
    } t_geom;

    typedef struct packed {
        logic [PW-1:0]    p;
        logic [GW-1:0]    g;
        logic [WID_W-1:0] f;
    } t_lane;

    typedef struct packed {
        t_geom           geom;
        logic [L2_W-1:0] l2;
        logic [PW-1:0]   n2x;
        logic [PW-1:0]   n2y;
        t_lane           lx;
        t_lane           ly;
    } t_sq;

    // One bit of floor(sqrt(n2 / l2)): try f + 2^b, keeping p = f^2*l2, g = f*l2.
    function automatic t_lane sq_step(t_lane a, logic [L2_W-1:0] l2,
                                      logic [PW-1:0] n2, int unsigned b);
        logic [PW-1:0] cand;
        t_lane r;
        cand = a.p + (PW'(a.g) << (b + 1)) + (PW'(l2) << (2 * b));
        r = a;
        if (cand <= n2) begin
            r.p = cand;
            r.g = a.g + (GW'(l2) << b);
            r.f = a.f | (WID_W'(1) << b);
        end
        return r;
    endfunction
endpackage

>>> rtl/tlq_front.sv
`timescale 1ns / 1ps
// Swap, delta, squares and products: three register stages.
module tlq_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [tlq_pkg::COORD_BITS-1:0]   i_sx,
    input  logic [tlq_pkg::COORD_BITS-1:0]   i_sy,
    input  logic [tlq_pkg::COORD_BITS-1:0]   i_ex,
    input  logic [tlq_pkg::COORD_BITS-1:0]   i_ey,
    input  logic [tlq_pkg::WID_W-1:0]        i_width,
    output logic                             o_valid,
    output tlq_pkg::t_sq                     o_sq
);
    localparam int C = tlq_pkg::COORD_BITS;

    logic [2:0] r_v;

    tlq_pkg::t_geom n_g1, r_g1, r_g2;
    logic [C-1:0] n_adx, r_adx, n_dy, r_dy;
    logic [tlq_pkg::L2_W-1:0] r_l2;
    logic [tlq_pkg::NUM_W-1:0] r_numx, r_numy;
    tlq_pkg::t_sq r_sq;

    always_comb begin
        if (i_ey < i_sy) begin
            n_g1.sx = i_ex; n_g1.sy = i_ey; n_g1.ex = i_sx; n_g1.ey = i_sy;
        end else begin
            n_g1.sx = i_sx; n_g1.sy = i_sy; n_g1.ex = i_ex; n_g1.ey = i_ey;
        end
        n_g1.neg   = n_g1.ex < n_g1.sx;
        n_g1.degen = (n_g1.ex == n_g1.sx) && (n_g1.ey == n_g1.sy);
        n_adx = n_g1.neg ? (n_g1.sx - n_g1.ex) : (n_g1.ex - n_g1.sx);
        n_dy  = n_g1.ey - n_g1.sy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g1   <= n_g1;
            r_adx  <= n_adx;
            r_dy   <= n_dy;
            r_g2   <= r_g1;
            r_l2   <= tlq_pkg::L2_W'(r_adx * r_adx) + tlq_pkg::L2_W'(r_dy * r_dy);
            r_numx <= tlq_pkg::NUM_W'(r_adx * i_width);
            r_numy <= tlq_pkg::NUM_W'(r_dy * i_width);
            r_sq.geom <= r_g2;
            r_sq.l2   <= r_l2;
            r_sq.n2x  <= tlq_pkg::PW'(r_numx * r_numx);
            r_sq.n2y  <= tlq_pkg::PW'(r_numy * r_numy);
            r_sq.lx   <= '0;
            r_sq.ly   <= '0;
        end
    end

    assign o_valid = r_v[2];
    assign o_sq    = r_sq;
endmodule

>>> rtl/tlq_isqrt.sv
`timescale 1ns / 1ps
// Bit-per-stage integer root of n2/l2 for both offset lanes.
module tlq_isqrt (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  tlq_pkg::t_sq i_sq,
    output logic         o_valid,
    output tlq_pkg::t_sq o_sq
);
    localparam int N = tlq_pkg::SQ_STEPS;

    logic [N-1:0] r_v;
    tlq_pkg::t_sq r_sq [N];
    tlq_pkg::t_sq n_sq [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_st
        tlq_pkg::t_sq src;
        if (k == 0) begin : g_first
            assign src = i_sq;
        end else begin : g_next
            assign src = r_sq[k-1];
        end
        always_comb begin
            n_sq[k]    = src;
            n_sq[k].lx = tlq_pkg::sq_step(src.lx, src.l2, src.n2x, N - 1 - k);
            n_sq[k].ly = tlq_pkg::sq_step(src.ly, src.l2, src.n2y, N - 1 - k);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k] <= n_sq[k];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_sq    = r_sq[N-1];
endmodule

>>> rtl/tlq_emit.sv
`timescale 1ns / 1ps
// Holds one segment and walks its ten vertices out (one word if degenerate), one word per cycle while not stalled.
module tlq_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  tlq_pkg::t_sq                  i_sq,
    input  logic [tlq_pkg::COLOR_W-1:0]   i_line_color,
    input  logic [tlq_pkg::COLOR_W-1:0]   i_back_color,
    input  logic                          i_stall,
    output logic                          o_load,
    output logic                          o_valid,
    output logic signed [tlq_pkg::VERT_W-1:0] o_vert_x,
    output logic signed [tlq_pkg::VERT_W-1:0] o_vert_y,
    output logic [tlq_pkg::COLOR_W-1:0]   o_vert_color,
    output logic                          o_strip_kind,
    output logic                          o_is_last,
    output logic                          o_degenerate
);
    localparam int V = tlq_pkg::VERT_W;
    localparam int F = tlq_pkg::FRAC_BITS;
    localparam logic [tlq_pkg::IDX_W-1:0] LAST_IDX = 4'd9;

    typedef enum logic [1:0] {OFF_N, OFF_ZERO, OFF_MN, OFF_MD} t_off;

    logic r_busy, r_degen;
    logic [tlq_pkg::IDX_W-1:0] r_idx;
    logic signed [V-1:0] r_sx, r_sy, r_ex, r_ey, r_ax, r_ay;

    logic fire, last;
    logic [tlq_pkg::WID_W:0] qx, qy;
    logic signed [V-1:0] mx, my;
    logic use_end, use_line;
    t_off off;
    logic signed [V-1:0] bx, by, ox, oy;

    assign fire   = r_busy && !i_stall;
    assign last   = r_degen || (r_idx == LAST_IDX);
    assign o_load = !r_busy || (fire && last);

    always_comb begin
        qx = ({1'b0, i_sq.lx.f} + 1'b1) >> 1;
        qy = ({1'b0, i_sq.ly.f} + 1'b1) >> 1;
        mx = V'(qx);
        my = V'(qy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_load) begin
            r_busy <= i_valid;
            r_idx  <= '0;
        end else if (fire) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_degen <= i_sq.geom.degen;
            r_sx    <= V'({i_sq.geom.sx, F'(0)});
            r_sy    <= V'({i_sq.geom.sy, F'(0)});
            r_ex    <= V'({i_sq.geom.ex, F'(0)});
            r_ey    <= V'({i_sq.geom.ey, F'(0)});
            r_ax    <= i_sq.geom.neg ? -mx : mx;
            r_ay    <= my;
        end
    end

    // Vertex table: base point, offset and colour per position.
    always_comb begin
        unique case (r_idx)
            4'd0:    begin use_end = 1'b0; off = OFF_N;    use_line = 1'b0; end
            4'd1:    begin use_end = 1'b1; off = OFF_N;    use_line = 1'b0; end
            4'd2:    begin use_end = 1'b0; off = OFF_ZERO; use_line = 1'b1; end
            4'd3:    begin use_end = 1'b1; off = OFF_ZERO; use_line = 1'b1; end
            4'd4:    begin use_end = 1'b0; off = OFF_MN;   use_line = 1'b0; end
            4'd5:    begin use_end = 1'b1; off = OFF_MN;   use_line = 1'b0; end
            4'd6:    begin use_end = 1'b0; off = OFF_N;    use_line = 1'b0; end
            4'd7:    begin use_end = 1'b0; off = OFF_MD;   use_line = 1'b0; end
            4'd8:    begin use_end = 1'b0; off = OFF_ZERO; use_line = 1'b1; end
            default: begin use_end = 1'b0; off = OFF_MN;   use_line = 1'b0; end
        endcase
        bx = use_end ? r_ex : r_sx;
        by = use_end ? r_ey : r_sy;
        // normal is (-ay, ax)
        unique case (off)
            OFF_N:    begin ox = -r_ay; oy = r_ax;  end
            OFF_ZERO: begin ox = '0;    oy = '0;    end
            OFF_MN:   begin ox = r_ay;  oy = -r_ax; end
            default:  begin ox = -r_ax; oy = -r_ay; end
        endcase
    end

    assign o_valid      = r_busy;
    assign o_vert_x     = r_degen ? '0 : bx + ox;
    assign o_vert_y     = r_degen ? '0 : by + oy;
    assign o_vert_color = r_degen ? '0 : (use_line ? i_line_color : i_back_color);
    assign o_strip_kind = !r_degen && (r_idx > 4'd5);
    assign o_is_last    = last;
    assign o_degenerate = r_degen;
endmodule

>>> rtl/thick_line_quad_tessellator.sv
`timescale 1ns / 1ps
// Wide line tessellator. Each accepted segment word (integer pixel endpoints)
// yields ten vertex words in 1/16 pixel: a six-vertex body strip followed by
// a four-vertex start cap strip; coinciding endpoints yield one word flagged
// degenerate. The vertex output moves one word per cycle while i_stall is low;
// the vertex walker loads the next segment as the last word of the current one
// is taken, and the pipeline can hold further segments meanwhile. A segment
// passes the 3 front stages and the 12 root stages, then the vertex walker
// load, before its first vertex word is presented. The half-width offsets come
// from a 12-stage integer square root pipeline.
// Config writes are always ready and should be made while the block is idle.
`include "assert_macros.svh"
module thick_line_quad_tessellator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [11:0]                        i_start_x,
    input  logic [11:0]                        i_start_y,
    input  logic [11:0]                        i_end_x,
    input  logic [11:0]                        i_end_y,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [tlq_pkg::VERT_W-1:0]  o_vert_x,
    output logic signed [tlq_pkg::VERT_W-1:0]  o_vert_y,
    output logic [tlq_pkg::COLOR_W-1:0]        o_vert_color,
    output logic                               o_strip_kind,
    output logic                               o_is_last,
    output logic                               o_degenerate,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tlq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);
    localparam int C = tlq_pkg::COORD_BITS;

    logic [tlq_pkg::WID_W-1:0]   r_line_width;
    logic [tlq_pkg::COLOR_W-1:0] r_line_color, r_back_color;

    logic adv, emit_load;
    logic fr_v, sq_v;
    tlq_pkg::t_sq fr_sq, sq_sq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= tlq_pkg::RST_LINE_WIDTH;
            r_line_color <= tlq_pkg::RST_LINE_COLOR;
            r_back_color <= tlq_pkg::RST_BACK_COLOR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tlq_pkg::CFG_LINE_WIDTH: r_line_width <= i_cfg_data[tlq_pkg::WID_W-1:0];
                tlq_pkg::CFG_LINE_COLOR: r_line_color <= i_cfg_data;
                tlq_pkg::CFG_BACK_COLOR: r_back_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipe moves together; it only holds when its last stage has a
    // segment the vertex walker cannot take yet.
    assign adv     = !sq_v || emit_load;
    assign o_stall = !adv;

    tlq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_sx    (i_start_x[C-1:0]),
        .i_sy    (i_start_y[C-1:0]),
        .i_ex    (i_end_x[C-1:0]),
        .i_ey    (i_end_y[C-1:0]),
        .i_width (r_line_width),
        .o_valid (fr_v),
        .o_sq    (fr_sq)
    );

    tlq_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (fr_v),
        .i_sq    (fr_sq),
        .o_valid (sq_v),
        .o_sq    (sq_sq)
    );

    tlq_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (sq_v),
        .i_sq         (sq_sq),
        .i_line_color (r_line_color),
        .i_back_color (r_back_color),
        .i_stall      (i_stall),
        .o_load       (emit_load),
        .o_valid      (o_valid),
        .o_vert_x     (o_vert_x),
        .o_vert_y     (o_vert_y),
        .o_vert_color (o_vert_color),
        .o_strip_kind (o_strip_kind),
        .o_is_last    (o_is_last),
        .o_degenerate (o_degenerate)
    );

    `ASSERT_CLK(a_degen_last, i_clk, i_rst_n, o_valid && o_degenerate |-> o_is_last, "degenerate word not last")
    `ASSERT_CLK(a_body_not_last, i_clk, i_rst_n, o_valid && !o_strip_kind && !o_degenerate |-> !o_is_last, "body vertex flagged last")
    `ASSERT_ALWAYS(a_stall_busy, i_clk, o_stall |-> o_valid, "input held while output idle")
endmodule
